// ===== sv/mcsk_pkg.sv =====
package mcsk_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Item kinds; codes five to seven are ignored.
  localparam logic [2:0] KIND_SPEED = 3'd0;
  localparam logic [2:0] KIND_DUTY  = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_BRAKE = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic [1:0] MODE_RPM     = 2'd0;
  localparam logic [1:0] MODE_DUTY    = 2'd1;
  localparam logic [1:0] MODE_CURRENT = 2'd2;
  localparam logic [1:0] MODE_BRAKE   = 2'd3;

  localparam logic [2:0] REG_INVERT    = 3'd0;
  localparam logic [2:0] REG_GEAR      = 3'd1;
  localparam logic [2:0] REG_STEP      = 3'd2;
  localparam logic [2:0] REG_INTERVAL  = 3'd3;
  localparam logic [2:0] REG_BRAKE_CUR = 3'd4;
  localparam logic [2:0] REG_DEVICE_ID = 3'd5;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [7:0]  GEAR_RST      = 8'd1;
  localparam logic [16:0] STEP_RST      = 17'd655;
  localparam logic [15:0] INTERVAL_RST  = 16'd100;
  localparam logic [30:0] BRAKE_CUR_RST = 31'd655360;

  typedef struct packed {
    logic        invert_direction;
    logic [7:0]  gear_ratio;
    logic [16:0] duty_step;
    logic [15:0] keepalive_ms;
    logic [30:0] brake_current;
    logic [7:0]  device_id;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic               brake_on;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]         command_mode;
    logic signed [31:0] command_value;
    logic [7:0]         target_id;
    logic               is_heartbeat;
  } result_t;

endpackage

// ===== sv/motor_command_slew_keepalive_unit.sv =====
// Motor command shaper with duty slew limiting and keep-alive resend.
// Input channel (in_valid/in_ready): one speed, duty, stop, brake or tick item
// per transfer, stamped with the millisecond time in in_now_ms.
// Result channel (out_valid/out_ready): zero or one command per item, in item
// order, carrying mode, signed Q16.16 value, device address and heartbeat flag.
// Configuration goes through the APB port (registers at byte address 4*i).
// The user must write it only while the block holds no work; the block
// itself does not enforce this. pready is always high. An accepted item sits
// in the input register until the output register is free or being emptied,
// is then evaluated against the command history, and its command, if any,
// lands in the output register. Throughput is one item per clock while
// out_ready is high; the single evaluation pass (one 32x9 multiply for speed
// scaling, one 33-bit compare and add for the duty ramp) sets that figure.
// When out_ready is low the output register holds its command and the input
// register can still take one more item; further items then wait.
// Synchronous reset clears the command history, the duty ramp and both stage
// valids, and loads the configuration reset values.
module motor_command_slew_keepalive_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_kind,
  input  logic signed [31:0]          in_value,
  input  logic                        in_brake_on,
  input  logic [31:0]                 in_now_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_command_mode,
  output logic signed [31:0]          out_command_value,
  output logic [7:0]                  out_target_id,
  output logic                        out_is_heartbeat,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcsk_pkg::ADDR_W-1:0] paddr,
  input  logic [mcsk_pkg::DATA_W-1:0] pwdata,
  output logic [mcsk_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mcsk_pkg::*;

  cfg_t    cfg;
  logic    in_vld_r, in_vld_nxt;
  item_t   in_item_r;
  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;
  logic    proc_go;
  logic    res_vld;
  result_t res;

  assign pready = 1'b1;

  mcsk_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mcsk_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (proc_go),
    .item    (in_item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  // The held item is evaluated once the output register is free or being emptied.
  assign proc_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc_go;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (proc_go) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (proc_go && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.kind     <= in_kind;
      in_item_r.value    <= in_value;
      in_item_r.brake_on <= in_brake_on;
      in_item_r.now_ms   <= in_now_ms;
    end
    if (proc_go && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_command_mode  = out_res_r.command_mode;
  assign out_command_value = out_res_r.command_value;
  assign out_target_id     = out_res_r.target_id;
  assign out_is_heartbeat  = out_res_r.is_heartbeat;

  a_hb_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && res_vld && res.is_heartbeat) |-> (in_item_r.kind == KIND_TICK))
    else $error("heartbeat produced by a non-tick item");

  a_item_held_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc_go) |=> (in_vld_r && $stable(in_item_r)))
    else $error("waiting item lost or changed");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && res_vld) |=> out_vld_r)
    else $error("evaluated command did not reach the output register");

endmodule

// ===== sv/mcsk_regs.sv =====
module mcsk_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcsk_pkg::ADDR_W-1:0] paddr,
  input  logic [mcsk_pkg::DATA_W-1:0] pwdata,
  output logic [mcsk_pkg::DATA_W-1:0] prdata,
  output mcsk_pkg::cfg_t              cfg
);
  import mcsk_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[ADDR_W-1:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_direction <= 1'b0;
      cfg_r.gear_ratio       <= GEAR_RST;
      cfg_r.duty_step        <= STEP_RST;
      cfg_r.keepalive_ms     <= INTERVAL_RST;
      cfg_r.brake_current    <= BRAKE_CUR_RST;
      cfg_r.device_id        <= 8'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_INVERT:    cfg_r.invert_direction <= pwdata[0];
        REG_GEAR:      cfg_r.gear_ratio       <= pwdata[7:0];
        REG_STEP:      cfg_r.duty_step        <= pwdata[16:0];
        REG_INTERVAL:  cfg_r.keepalive_ms     <= pwdata[15:0];
        REG_BRAKE_CUR: cfg_r.brake_current    <= pwdata[30:0];
        REG_DEVICE_ID: cfg_r.device_id        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INVERT:    prdata = {31'd0, cfg_r.invert_direction};
      REG_GEAR:      prdata = {24'd0, cfg_r.gear_ratio};
      REG_STEP:      prdata = {15'd0, cfg_r.duty_step};
      REG_INTERVAL:  prdata = {16'd0, cfg_r.keepalive_ms};
      REG_BRAKE_CUR: prdata = {1'b0, cfg_r.brake_current};
      REG_DEVICE_ID: prdata = {24'd0, cfg_r.device_id};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== sv/mcsk_core.sv =====
module mcsk_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  mcsk_pkg::item_t   item,
  input  mcsk_pkg::cfg_t    cfg,
  output logic              res_vld,
  output mcsk_pkg::result_t res
);
  import mcsk_pkg::*;

  // Command history and duty ramp state.
  logic               last_sent_r, last_sent_nxt;
  logic [1:0]         last_mode_r, last_mode_nxt;
  logic signed [31:0] last_value_r, last_value_nxt;
  logic [31:0]        last_send_r, last_send_nxt;
  logic signed [31:0] tgt_r, tgt_nxt;
  logic signed [31:0] pres_r, pres_nxt;

  logic signed [31:0] req;
  logic [7:0]         gear;
  logic signed [40:0] prod;
  logic signed [31:0] speed_cmd;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic signed [31:0] ramp;
  logic [31:0]        elapsed;

  logic               cand_vld;
  logic [1:0]         cand_mode;
  logic signed [31:0] cand_value;
  logic               cand_hb;
  logic               emit;

  always_comb begin
    if (cfg.invert_direction) begin
      req = (item.value == S32_MIN) ? S32_MAX : -item.value;
    end else begin
      req = item.value;
    end
  end

  assign gear = (cfg.gear_ratio == 8'd0) ? 8'd1 : cfg.gear_ratio;
  assign prod = 41'(req) * 41'(signed'({1'b0, gear}));

  // The product fits when bits 40 down to 31 all agree.
  always_comb begin
    if (!prod[40] && (|prod[39:31])) begin
      speed_cmd = S32_MAX;
    end else if (prod[40] && !(&prod[39:31])) begin
      speed_cmd = S32_MIN;
    end else begin
      speed_cmd = prod[31:0];
    end
  end

  assign diff = 33'(tgt_r) - 33'(pres_r);
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    if (mag <= {16'd0, cfg.duty_step}) begin
      ramp = tgt_r;
    end else if (!diff[32]) begin
      ramp = pres_r + signed'({15'd0, cfg.duty_step});
    end else begin
      ramp = pres_r - signed'({15'd0, cfg.duty_step});
    end
  end

  assign elapsed = item.now_ms - last_send_r;

  always_comb begin
    cand_vld   = 1'b0;
    cand_mode  = MODE_CURRENT;
    cand_value = '0;
    cand_hb    = 1'b0;
    tgt_nxt    = tgt_r;
    pres_nxt   = pres_r;
    unique case (item.kind)
      KIND_SPEED: begin
        tgt_nxt  = '0;
        pres_nxt = '0;
        cand_vld = 1'b1;
        if (req != 32'sd0) begin
          cand_mode  = MODE_RPM;
          cand_value = speed_cmd;
        end
      end
      KIND_DUTY: begin
        tgt_nxt = req;
        if (req == 32'sd0) begin
          pres_nxt = '0;
          cand_vld = 1'b1;
        end
      end
      KIND_STOP: begin
        tgt_nxt  = '0;
        pres_nxt = '0;
        cand_vld = 1'b1;
      end
      KIND_BRAKE: begin
        tgt_nxt  = '0;
        pres_nxt = '0;
        cand_vld = 1'b1;
        if (item.brake_on) begin
          cand_mode  = MODE_BRAKE;
          cand_value = signed'({1'b0, cfg.brake_current});
        end
      end
      KIND_TICK: begin
        if (tgt_r != pres_r) begin
          pres_nxt   = ramp;
          cand_vld   = 1'b1;
          cand_mode  = MODE_DUTY;
          cand_value = ramp;
        end else if (last_sent_r && (elapsed >= {16'd0, cfg.keepalive_ms})) begin
          cand_vld   = 1'b1;
          cand_mode  = last_mode_r;
          cand_value = last_value_r;
          cand_hb    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // A fresh command is dropped when it repeats the last one sent; a heartbeat is not.
  assign emit = cand_vld && (cand_hb || !(last_sent_r && (last_mode_r == cand_mode) &&
                                          (last_value_r == cand_value)));

  always_comb begin
    last_sent_nxt  = last_sent_r;
    last_mode_nxt  = last_mode_r;
    last_value_nxt = last_value_r;
    last_send_nxt  = last_send_r;
    if (emit) begin
      last_sent_nxt  = 1'b1;
      last_mode_nxt  = cand_mode;
      last_value_nxt = cand_value;
      last_send_nxt  = item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sent_r  <= 1'b0;
      last_mode_r  <= MODE_RPM;
      last_value_r <= '0;
      last_send_r  <= '0;
      tgt_r        <= '0;
      pres_r       <= '0;
    end else if (step_en) begin
      last_sent_r  <= last_sent_nxt;
      last_mode_r  <= last_mode_nxt;
      last_value_r <= last_value_nxt;
      last_send_r  <= last_send_nxt;
      tgt_r        <= tgt_nxt;
      pres_r       <= pres_nxt;
    end
  end

  assign res_vld           = emit;
  assign res.command_mode  = cand_mode;
  assign res.command_value = cand_value;
  assign res.target_id     = cfg.device_id;
  assign res.is_heartbeat  = cand_hb;

endmodule
